@@ src/mfld_pkg.sv @@
// Package with the shared constants, command codes, state encoding and control structs.
package mfld_pkg;

    localparam int SCREEN_WIDTH  = 128;
    localparam int SCREEN_HEIGHT = 64;
    localparam int PAGE_ROWS     = 8;
    localparam int PAGE_COUNT    = (SCREEN_HEIGHT + PAGE_ROWS - 1) / PAGE_ROWS;
    localparam int STORE_SIZE    = SCREEN_WIDTH * PAGE_COUNT;
    localparam int ADDR_W        = $clog2(STORE_SIZE);
    localparam int ROW_BIT_W     = $clog2(PAGE_ROWS);
    localparam int COORD_W       = 10;
    localparam int BYTE_ADDR_W   = 10;
    localparam int DATA_W        = 8;
    localparam int ERR_W         = COORD_W + 3;
    localparam int CMP_W         = BYTE_ADDR_W + ADDR_W + 1;

    typedef logic signed [COORD_W-1:0] t_coord;

    typedef enum logic [1:0] {
        CMD_CLEAR = 2'd0,
        CMD_PIXEL = 2'd1,
        CMD_LINE  = 2'd2,
        CMD_READ  = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_CLEAR,
        ST_DRAW,
        ST_READ,
        ST_FIN
    } t_state;

    typedef struct packed {
        logic load;
        logic clr_en;
        logic walk_en;
        logic rd_en;
        logic out_load;
    } t_dp_ctl;

    typedef struct packed {
        logic clr_last;
        logic walk_last;
    } t_dp_sts;

endpackage

@@ src/mfld_if.sv @@
// Valid/ready channel interfaces for the command input and the result output.
interface mfld_in_if;
    import mfld_pkg::*;
    logic                   valid;
    logic                   ready;
    logic [1:0]             cmd;
    logic signed [COORD_W-1:0] x_start;
    logic signed [COORD_W-1:0] y_start;
    logic signed [COORD_W-1:0] x_end;
    logic signed [COORD_W-1:0] y_end;
    logic                   pixel_on;
    logic [BYTE_ADDR_W-1:0] byte_addr;

    modport source (output valid, cmd, x_start, y_start, x_end, y_end, pixel_on, byte_addr,
                    input ready);
    modport sink (input valid, cmd, x_start, y_start, x_end, y_end, pixel_on, byte_addr,
                  output ready);
endinterface

interface mfld_out_if;
    import mfld_pkg::*;
    logic              valid;
    logic              ready;
    logic [DATA_W-1:0] read_data;

    modport source (output valid, read_data, input ready);
    modport sink (input valid, read_data, output ready);
endinterface

@@ src/mfld_dp.sv @@
// Datapath: framebuffer memory, clear counter, line stepper and read-modify-write stage.
module mfld_dp (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  mfld_pkg::t_dp_ctl               i_ctl,
    output mfld_pkg::t_dp_sts               o_sts,
    input  logic [1:0]                      i_cmd,
    input  logic signed [mfld_pkg::COORD_W-1:0] i_x_start,
    input  logic signed [mfld_pkg::COORD_W-1:0] i_y_start,
    input  logic signed [mfld_pkg::COORD_W-1:0] i_x_end,
    input  logic signed [mfld_pkg::COORD_W-1:0] i_y_end,
    input  logic                            i_pixel_on,
    input  logic [mfld_pkg::BYTE_ADDR_W-1:0] i_byte_addr,
    output logic [mfld_pkg::DATA_W-1:0]     o_read_data
);
    import mfld_pkg::*;

    localparam t_coord X_LIM = COORD_W'(SCREEN_WIDTH);
    localparam t_coord Y_LIM = COORD_W'(SCREEN_HEIGHT);

    logic [DATA_W-1:0] r_frame [STORE_SIZE];
    logic [DATA_W-1:0] r_q;

    // Command context.
    logic                   r_is_read;
    logic                   r_rd_ok;
    logic [BYTE_ADDR_W-1:0] r_addr;
    logic                   r_on;

    // Line walker state.
    t_coord r_x, r_y, r_xe, r_ye;
    logic   r_sx_neg, r_sy_neg;
    logic signed [ERR_W-1:0] r_dx, r_dy, r_err;

    // Clear sweep.
    logic [ADDR_W-1:0] r_clr_cnt;

    // Read-modify-write stage and forwarding of the previous write.
    logic              r_pend_valid;
    logic [ADDR_W-1:0] r_pend_addr;
    logic [DATA_W-1:0] r_pend_mask;
    logic              r_last_valid;
    logic [ADDR_W-1:0] r_last_addr;
    logic [DATA_W-1:0] r_last_data;

    logic [DATA_W-1:0] r_out_data;

    // Load-time values.
    t_coord                  ld_xe, ld_ye;
    logic signed [ERR_W-1:0] ld_ddx, ld_ddy, ld_dx, ld_dy;

    // Walk-time values.
    logic signed [ERR_W:0]   e2;
    logic                    step_x, step_y;
    logic signed [ERR_W-1:0] n_err;
    logic                    on_screen;
    logic [ADDR_W-1:0]       pt_addr;
    logic [DATA_W-1:0]       pt_mask;

    // Memory port controls.
    logic              mem_re, mem_we;
    logic [ADDR_W-1:0] mem_raddr, mem_waddr;
    logic [DATA_W-1:0] mem_wdata, rmw_base, rmw_data;

    always_comb begin
        ld_xe  = (i_cmd == CMD_LINE) ? i_x_end : i_x_start;
        ld_ye  = (i_cmd == CMD_LINE) ? i_y_end : i_y_start;
        ld_ddx = ERR_W'(ld_xe) - ERR_W'(i_x_start);
        ld_ddy = ERR_W'(ld_ye) - ERR_W'(i_y_start);
        ld_dx  = ld_ddx[ERR_W-1] ? -ld_ddx : ld_ddx;
        ld_dy  = ld_ddy[ERR_W-1] ? ld_ddy : -ld_ddy;
    end

    always_comb begin
        e2     = (ERR_W + 1)'(r_err) <<< 1;
        step_x = e2 >= (ERR_W + 1)'(r_dy);
        step_y = e2 <= (ERR_W + 1)'(r_dx);
        n_err  = r_err + (step_x ? r_dy : '0) + (step_y ? r_dx : '0);
        on_screen = !r_x[COORD_W-1] && !r_y[COORD_W-1] && (r_x < X_LIM) && (r_y < Y_LIM);
        pt_addr   = ADDR_W'(r_x) + ADDR_W'(r_y >>> ROW_BIT_W) * ADDR_W'(SCREEN_WIDTH);
        pt_mask   = DATA_W'(1) << r_y[ROW_BIT_W-1:0];
    end

    always_comb begin
        rmw_base  = (r_last_valid && (r_last_addr == r_pend_addr)) ? r_last_data : r_q;
        rmw_data  = r_on ? (rmw_base | r_pend_mask) : (rmw_base & ~r_pend_mask);
        mem_re    = (i_ctl.walk_en && on_screen) || i_ctl.rd_en;
        mem_raddr = i_ctl.rd_en ? ADDR_W'(r_addr) : pt_addr;
        mem_we    = r_pend_valid || i_ctl.clr_en;
        mem_waddr = i_ctl.clr_en ? r_clr_cnt : r_pend_addr;
        mem_wdata = i_ctl.clr_en ? '0 : rmw_data;
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_frame[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_q <= r_frame[mem_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_is_read <= (i_cmd == CMD_READ);
            r_rd_ok   <= CMP_W'(i_byte_addr) < CMP_W'(STORE_SIZE);
            r_addr    <= i_byte_addr;
            r_on      <= (i_cmd == CMD_LINE) || i_pixel_on;
            r_x       <= i_x_start;
            r_y       <= i_y_start;
            r_xe      <= ld_xe;
            r_ye      <= ld_ye;
            r_sx_neg  <= !(i_x_start < ld_xe);
            r_sy_neg  <= !(i_y_start < ld_ye);
            r_dx      <= ld_dx;
            r_dy      <= ld_dy;
            r_err     <= ld_dx + ld_dy;
        end else if (i_ctl.walk_en) begin
            r_err <= n_err;
            if (step_x) begin
                r_x <= r_x + (r_sx_neg ? t_coord'(-1) : t_coord'(1));
            end
            if (step_y) begin
                r_y <= r_y + (r_sy_neg ? t_coord'(-1) : t_coord'(1));
            end
        end
        r_pend_addr <= pt_addr;
        r_pend_mask <= pt_mask;
        r_last_addr <= r_pend_addr;
        r_last_data <= rmw_data;
        if (i_ctl.out_load) begin
            r_out_data <= (r_is_read && r_rd_ok) ? r_q : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_cnt    <= '0;
            r_pend_valid <= 1'b0;
            r_last_valid <= 1'b0;
        end else begin
            if (i_ctl.clr_en) begin
                r_clr_cnt <= o_sts.clr_last ? '0 : r_clr_cnt + ADDR_W'(1);
            end
            r_pend_valid <= i_ctl.walk_en && on_screen;
            r_last_valid <= r_pend_valid;
        end
    end

    assign o_sts.clr_last  = (r_clr_cnt == ADDR_W'(STORE_SIZE - 1));
    assign o_sts.walk_last = (r_x == r_xe) && (r_y == r_ye);
    assign o_read_data     = r_out_data;

endmodule

@@ src/mfld_ctrl.sv @@
// Controller state machine: sequences clear sweeps, line walks and reads, and owns the handshakes.
module mfld_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic [1:0]        i_cmd,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output mfld_pkg::t_dp_ctl o_ctl,
    input  mfld_pkg::t_dp_sts i_sts
);
    import mfld_pkg::*;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   accept;

    assign accept = (r_state == ST_IDLE) && i_in_valid;

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_INIT: begin
                if (i_sts.clr_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_in_valid) begin
                    case (i_cmd)
                        CMD_CLEAR: n_state = ST_CLEAR;
                        CMD_PIXEL: n_state = ST_DRAW;
                        CMD_LINE:  n_state = ST_DRAW;
                        CMD_READ:  n_state = ST_READ;
                        default:   n_state = ST_READ;
                    endcase
                end
            end
            ST_CLEAR: begin
                if (i_sts.clr_last) begin
                    n_state = ST_FIN;
                end
            end
            ST_DRAW: begin
                if (i_sts.walk_last) begin
                    n_state = ST_FIN;
                end
            end
            ST_READ: n_state = ST_FIN;
            ST_FIN: begin
                if (!r_out_valid || i_out_ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_INIT;
        endcase
    end

    always_comb begin
        o_ctl          = '0;
        o_in_ready     = 1'b0;
        o_ctl.load     = accept;
        case (r_state)
            ST_INIT:  o_ctl.clr_en = 1'b1;
            ST_IDLE:  o_in_ready = 1'b1;
            ST_CLEAR: o_ctl.clr_en = 1'b1;
            ST_DRAW:  o_ctl.walk_en = 1'b1;
            ST_READ:  o_ctl.rd_en = 1'b1;
            ST_FIN:   o_ctl.out_load = !r_out_valid || i_out_ready;
            default:  o_ctl = '0;
        endcase
        if (o_ctl.out_load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_INIT;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

@@ src/monochrome_framebuffer_line_drawer.sv @@
// Top level of the monochrome framebuffer drawing engine.
//
//   Channel  Direction  Payload                                             Handshake
//   i_in     sink       cmd, x_start, y_start, x_end, y_end, pixel_on,      valid/ready
//                       byte_addr
//   o_out    source     read_data                                           valid/ready
//
// One command is worked at a time. Clear sweeps the store to zero with the single write
// port, one byte a cycle. Write pixel and draw line run the walker, which visits one
// point a cycle; the read-modify-write of each byte follows in the cycle after, with
// the previous write forwarded so that neighboring points in one byte do not stall.
// After reset the store is swept to zero before the first transaction is taken. A
// stalled result waits in the output register; the next command is accepted meanwhile
// and only waits at its own end for the register to empty.
module monochrome_framebuffer_line_drawer (
    input  logic       i_clk,
    input  logic       i_rst_n,
    mfld_in_if.sink    i_in,
    mfld_out_if.source o_out
);
    import mfld_pkg::*;

    t_dp_ctl ctl;
    t_dp_sts sts;

    // The controller decides when each datapath unit runs; the datapath reports
    // the end of a clear sweep and the last point of a line.
    mfld_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (i_in.ready),
        .i_cmd      (i_in.cmd),
        .o_out_valid(o_out.valid),
        .i_out_ready(o_out.ready),
        .o_ctl      (ctl),
        .i_sts      (sts)
    );

    // The datapath holds the framebuffer, the Bresenham walker and the result register.
    mfld_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (ctl),
        .o_sts      (sts),
        .i_cmd      (i_in.cmd),
        .i_x_start  (i_in.x_start),
        .i_y_start  (i_in.y_start),
        .i_x_end    (i_in.x_end),
        .i_y_end    (i_in.y_end),
        .i_pixel_on (i_in.pixel_on),
        .i_byte_addr(i_in.byte_addr),
        .o_read_data(o_out.read_data)
    );

endmodule

@@ src/mfld_chk.sv @@
// Port checker for the drawing engine and the bind that attaches it.
module mfld_chk (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       i_in_ready,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [7:0] i_read_data
);
    logic [1:0] r_cnt;
    logic       acc_in, acc_out;

    assign acc_in  = i_in_valid && i_in_ready;
    assign acc_out = i_out_valid && i_out_ready;

    // Transactions accepted but whose result has not been delivered.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= r_cnt + 2'(acc_in) - 2'(acc_out);
        end
    end

    // The store is swept after reset before any command is taken.
    a_init_sweep: assert property (@(posedge i_clk) !i_rst_n |=> !i_in_ready)
        else $error("input ready right after reset");

    // Commands are worked one at a time.
    a_no_back_to_back: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc_in |=> !i_in_ready)
        else $error("two commands accepted in consecutive cycles");

    // A result never appears without a command in flight, and at most two are open.
    a_result_has_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (r_cnt != 2'd0))
        else $error("result without an accepted command");

    a_open_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3)
        else $error("more than two commands open");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_read_data))
        else $error("stalled result changed");

endmodule

bind monochrome_framebuffer_line_drawer mfld_chk u_mfld_chk (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_in_valid (i_in.valid),
    .i_in_ready (i_in.ready),
    .i_out_valid(o_out.valid),
    .i_out_ready(o_out.ready),
    .i_read_data(o_out.read_data)
);
